@@ design/pte_pkg.sv @@
// Package with the constants, codes and sizes shared by the prefix trie engine.
package pte_pkg;

	localparam int MAX_NODES = 1024;
	localparam int ALPHABET  = 26;
	localparam int SLOTS     = MAX_NODES * ALPHABET;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int USED_W    = NODE_W + 1;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int CMD_W     = 2;
	localparam int SYM_W     = 5;
	localparam int STATUS_W  = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXACT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd3;

endpackage

@@ design/pte_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module pte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/prefix_trie_engine_unit.sv @@
// Top level of the prefix trie engine: walk sequencer around the child and word-mark memories.
//
//   channel  direction  handshake              payload
//   request  in         start, busy            cmd, letter, last
//   result   out        done (one-cycle pulse) status
//
// For a letter that is not the last of its word, the accept cycle issues the
// child memory read and the next cycle updates the cursor from the read data.
// A last letter of an insert or prefix search is handled the same way; a last letter of an
// exact search adds a further state after the update for the word-mark memory read.
// The result shows on done and status in the cycle after the final update.
// After reset a pass over all 26624 child slots zeroes both memories while busy stays high.
// The receiver cannot stall; a new request may be taken while a result is shown.
module prefix_trie_engine_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [pte_pkg::CMD_W-1:0]      cmd,
	input  logic [pte_pkg::SYM_W-1:0]      letter,
	input  logic                           last,
	output logic                           done,
	output logic [pte_pkg::STATUS_W-1:0]   status
);

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_MRK  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;

	logic [pte_pkg::SLOT_W-1:0]   clr_cnt_q;
	logic [pte_pkg::NODE_W-1:0]   cursor_q;
	logic [pte_pkg::USED_W-1:0]   nodes_used_q;
	logic                         path_missing_q;
	logic                         overflowed_q;
	logic                         done_q;
	logic [pte_pkg::STATUS_W-1:0] status_q;

	logic [pte_pkg::CMD_W-1:0]    cmd_s1;
	logic                         last_s1;
	logic                         walk_s1;
	logic [pte_pkg::SLOT_W-1:0]   addr_s1;

	logic                         accept;
	logic                         sym_ok;
	logic                         is_ins_in;
	logic                         walk_in;
	logic                         miss_in;
	logic [pte_pkg::SLOT_W-1:0]   rd_addr;

	logic                         is_ins;
	logic [pte_pkg::NODE_W-1:0]   child;
	logic [pte_pkg::NODE_W-1:0]   cur_nx;
	logic                         pm_nx;
	logic                         ov_nx;
	logic                         alloc;
	logic                         mark_set;
	logic                         fin;
	logic                         go_mrk;
	logic [pte_pkg::STATUS_W-1:0] status_nx;

	logic                         ch_we;
	logic [pte_pkg::SLOT_W-1:0]   ch_addr;
	logic [pte_pkg::NODE_W-1:0]   ch_wdata;
	logic                         mk_we;
	logic [pte_pkg::NODE_W-1:0]   mk_addr;
	logic                         mk_wdata;
	logic                         mk_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && (state_q == ST_IDLE);
	assign sym_ok    = (int'(letter) < pte_pkg::ALPHABET);
	assign is_ins_in = (cmd == pte_pkg::CMD_INSERT);
	assign walk_in   = sym_ok && (is_ins_in ? !overflowed_q : !path_missing_q);
	assign miss_in   = !is_ins_in && !sym_ok;
	assign rd_addr   = sym_ok ? (pte_pkg::SLOT_W'(cursor_q) * pte_pkg::SLOT_W'(pte_pkg::ALPHABET)
		+ pte_pkg::SLOT_W'(letter)) : '0;

	always_comb begin
		is_ins    = (cmd_s1 == pte_pkg::CMD_INSERT);
		cur_nx    = cursor_q;
		pm_nx     = path_missing_q;
		ov_nx     = overflowed_q;
		alloc     = 1'b0;
		mark_set  = 1'b0;
		fin       = 1'b0;
		go_mrk    = 1'b0;
		status_nx = pte_pkg::ST_NOT_FOUND;
		if (walk_s1) begin
			if (is_ins) begin
				if (child == '0) begin
					if (nodes_used_q >= pte_pkg::USED_W'(pte_pkg::MAX_NODES)) begin
						ov_nx = 1'b1;
					end else begin
						alloc  = 1'b1;
						cur_nx = nodes_used_q[pte_pkg::NODE_W-1:0];
					end
				end else begin
					cur_nx = child;
				end
			end else if (child == '0) begin
				pm_nx = 1'b1;
			end else begin
				cur_nx = child;
			end
		end
		if (last_s1) begin
			if (is_ins) begin
				fin = 1'b1;
				if (ov_nx) begin
					status_nx = pte_pkg::ST_POOL_FULL;
				end else begin
					mark_set  = 1'b1;
					status_nx = pte_pkg::ST_INSERTED;
				end
			end else if (pm_nx) begin
				fin       = 1'b1;
				status_nx = pte_pkg::ST_NOT_FOUND;
			end else if (cmd_s1 == pte_pkg::CMD_EXACT) begin
				go_mrk = 1'b1;
			end else begin
				fin       = 1'b1;
				status_nx = pte_pkg::ST_FOUND;
			end
		end
	end

	always_comb begin
		ch_we    = 1'b0;
		ch_addr  = rd_addr;
		ch_wdata = nodes_used_q[pte_pkg::NODE_W-1:0];
		mk_we    = 1'b0;
		mk_addr  = cur_nx;
		mk_wdata = 1'b1;
		case (state_q)
			ST_CLR: begin
				ch_we    = 1'b1;
				ch_addr  = clr_cnt_q;
				ch_wdata = '0;
				mk_we    = (clr_cnt_q < pte_pkg::SLOT_W'(pte_pkg::MAX_NODES));
				mk_addr  = clr_cnt_q[pte_pkg::NODE_W-1:0];
				mk_wdata = 1'b0;
			end
			ST_UPD: begin
				ch_we   = alloc;
				ch_addr = addr_s1;
				mk_we   = mark_set;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_cnt_q == pte_pkg::SLOT_W'(pte_pkg::SLOTS - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_nx = ST_UPD;
				end
			end
			ST_UPD: begin
				state_nx = go_mrk ? ST_MRK : ST_IDLE;
			end
			ST_MRK: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	pte_ram #(
		.WIDTH(pte_pkg::NODE_W),
		.DEPTH(pte_pkg::SLOTS)
	) u_children (
		.clk  (clk),
		.we   (ch_we),
		.addr (ch_addr),
		.wdata(ch_wdata),
		.rdata(child)
	);

	pte_ram #(
		.WIDTH(1),
		.DEPTH(pte_pkg::MAX_NODES)
	) u_marks (
		.clk  (clk),
		.we   (mk_we),
		.addr (mk_addr),
		.wdata(mk_wdata),
		.rdata(mk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			clr_cnt_q      <= '0;
			cursor_q       <= '0;
			nodes_used_q   <= pte_pkg::USED_W'(1);
			path_missing_q <= 1'b0;
			overflowed_q   <= 1'b0;
			walk_s1        <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= 1'b0;
			if (state_q == ST_CLR) begin
				clr_cnt_q <= clr_cnt_q + pte_pkg::SLOT_W'(1);
			end
			if (accept) begin
				walk_s1 <= walk_in;
				if (miss_in) begin
					path_missing_q <= 1'b1;
				end
			end
			if (state_q == ST_UPD) begin
				if (alloc) begin
					nodes_used_q <= nodes_used_q + pte_pkg::USED_W'(1);
				end
				if (last_s1) begin
					cursor_q       <= '0;
					path_missing_q <= 1'b0;
					overflowed_q   <= 1'b0;
				end else begin
					cursor_q       <= cur_nx;
					path_missing_q <= pm_nx;
					overflowed_q   <= ov_nx;
				end
				done_q <= fin;
			end
			if (state_q == ST_MRK) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			last_s1 <= last;
			addr_s1 <= rd_addr;
		end
		if (state_q == ST_UPD) begin
			status_q <= status_nx;
		end
		if (state_q == ST_MRK) begin
			status_q <= mk_rdata ? pte_pkg::ST_FOUND : pte_pkg::ST_NOT_FOUND;
		end
	end

	assign done   = done_q;
	assign status = status_q;

`ifndef ASSERT_OFF
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_UPD || $past(state_q) == ST_MRK))
		else $error("Result strobe without a finishing update or mark read.");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_used_q >= pte_pkg::USED_W'(1)
		&& nodes_used_q <= pte_pkg::USED_W'(pte_pkg::MAX_NODES))
		else $error("Node allocation count left its range.");

	a_cursor_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		pte_pkg::USED_W'(cursor_q) < nodes_used_q)
		else $error("Cursor points at a node that was never allocated.");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == pte_pkg::ST_POOL_FULL)
		|-> nodes_used_q == pte_pkg::USED_W'(pte_pkg::MAX_NODES))
		else $error("Pool full reported while nodes remain.");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> (!done_q && busy))
		else $error("Activity during the clearing pass.");
`endif

endmodule
